@@ sv/mlsq_pkg.sv @@
// Shared types and constants for the multi-list stack and queue engine.
// Used by mlsq_ctrl, mlsq_datapath and multi_list_stack_queue_engine.
`default_nettype none
package mlsq_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int POOL_DEPTH = 1024;
    localparam int WORD_WIDTH = 64;

    localparam int SLOT_W = 4;
    localparam int KIND_W = 2;
    localparam int STAT_W = 3;
    localparam int OUT_W  = 64;
    localparam int ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int PTR_W  = $clog2(POOL_DEPTH + 1);

    typedef logic [PTR_W-1:0]      t_ptr;
    typedef logic [WORD_WIDTH-1:0] t_word;

    // The null pointer is the pool depth itself.
    localparam t_ptr NIL = t_ptr'(POOL_DEPTH);

    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_EXISTS  = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_MISSING = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_EMPTY   = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_FULL    = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;        // capture the input operation
        logic              create;      // make the named slot exist, empty
        logic              free_rd;     // read the link of the free-list head
        logic              free_take;   // take the free-list head as the new node
        logic              fresh_take;  // take the next never-used node
        logic              push_link;   // chain the new node behind the queue tail
        logic              push_wr;     // write the new node and update the slot
        logic              pop_rd;      // read word and link of the slot head
        logic              pop_commit;  // unlink the head and free it
        logic              done;        // present a result
        logic [STAT_W-1:0] status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              in_range;
        logic              exists;
        logic              is_queue;
        logic              head_null;
        logic              tail_null;
        logic              free_avail;
        logic              fresh_avail;
    } t_stat;

endpackage
`default_nettype wire

@@ sv/mlsq_ctrl.sv @@
// Sequencing state machine of the multi-list stack and queue engine.
// Depends on mlsq_pkg; drives the command struct of mlsq_datapath.
`default_nettype none
module mlsq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire mlsq_pkg::t_stat i_stat,
    output mlsq_pkg::t_cmd     o_cmd,
    output logic               o_busy
);
    import mlsq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_GRAB,
        S_PUSH,
        S_WRITE,
        S_POP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    t_cmd   n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        n_cmd.status = STATUS_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (i_stat.kind == KIND_NOP) begin
                    n_cmd.done = 1'b1;
                end else if (!i_stat.in_range) begin
                    n_cmd.done   = 1'b1;
                    n_cmd.status = STATUS_MISSING;
                end else if (i_stat.kind == KIND_CREATE) begin
                    n_cmd.done = 1'b1;
                    if (i_stat.exists) begin
                        n_cmd.status = STATUS_EXISTS;
                    end else begin
                        n_cmd.create = 1'b1;
                    end
                end else if (!i_stat.exists) begin
                    n_cmd.done   = 1'b1;
                    n_cmd.status = STATUS_MISSING;
                end else if (i_stat.kind == KIND_PUSH) begin
                    if (i_stat.free_avail) begin
                        n_cmd.free_rd = 1'b1;
                        n_state       = S_GRAB;
                    end else if (i_stat.fresh_avail) begin
                        n_cmd.fresh_take = 1'b1;
                        n_state          = S_PUSH;
                    end else begin
                        n_cmd.done   = 1'b1;
                        n_cmd.status = STATUS_FULL;
                    end
                end else if (i_stat.head_null) begin
                    n_cmd.done   = 1'b1;
                    n_cmd.status = STATUS_EMPTY;
                end else begin
                    n_cmd.pop_rd = 1'b1;
                    n_state      = S_POP;
                end
            end
            S_GRAB: begin
                n_cmd.free_take = 1'b1;
                n_state         = S_PUSH;
            end
            S_PUSH: begin
                // A queue with a tail first chains the new node behind it.
                if (i_stat.is_queue && !i_stat.tail_null) begin
                    n_cmd.push_link = 1'b1;
                    n_state         = S_WRITE;
                end else begin
                    n_cmd.push_wr = 1'b1;
                    n_cmd.done    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_WRITE: begin
                n_cmd.push_wr = 1'b1;
                n_cmd.done    = 1'b1;
                n_state       = S_IDLE;
            end
            S_POP: begin
                n_cmd.pop_commit = 1'b1;
                n_cmd.done       = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_cmd.load) begin
                r_busy <= 1'b1;
            end else if (n_cmd.done) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_cmd  = n_cmd;
    assign o_busy = r_busy;

endmodule
`default_nettype wire

@@ sv/mlsq_datapath.sv @@
// Datapath of the multi-list stack and queue engine: slot table, free list,
// node pool memories and result registers. Depends on mlsq_pkg.
`default_nettype none
module mlsq_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire mlsq_pkg::t_cmd            i_cmd,
    input  wire logic [mlsq_pkg::KIND_W-1:0] i_kind,
    input  wire logic [mlsq_pkg::SLOT_W-1:0] i_list_slot,
    input  wire logic                      i_make_queue,
    input  wire logic [mlsq_pkg::OUT_W-1:0]  i_push_value,
    output mlsq_pkg::t_stat                o_stat,
    output logic                           o_valid,
    output logic [mlsq_pkg::STAT_W-1:0]      o_status,
    output logic [mlsq_pkg::OUT_W-1:0]       o_popped_value,
    output logic                           o_popped_valid
);
    import mlsq_pkg::*;

    // Captured operation.
    logic [KIND_W-1:0] r_kind;
    logic [SLOT_W-1:0] r_slot;
    logic              r_queue;
    t_word             r_val;

    // Slot table.
    logic r_exists   [NUM_SLOTS];
    logic r_is_queue [NUM_SLOTS];
    t_ptr r_head     [NUM_SLOTS];
    t_ptr r_tail     [NUM_SLOTS];

    // Allocation state.
    t_ptr r_free_head;
    t_ptr r_fresh_count;
    t_ptr r_node;

    // Node pool.
    t_ptr  link_mem [POOL_DEPTH];
    t_word word_mem [POOL_DEPTH];
    t_ptr  r_link_rd;
    t_word r_word_rd;

    // Result registers.
    logic              r_valid;
    logic [STAT_W-1:0] r_status;
    t_word             r_pop_word;
    logic              r_pop_valid;

    logic              in_range;
    t_ptr              cur_head;
    t_ptr              cur_tail;
    logic              cur_queue;
    logic              cur_exists;
    t_ptr              next_link;
    t_ptr              rd_ptr;
    logic              link_we;
    t_ptr              link_wptr;
    t_ptr              link_wdata;

    assign in_range   = ({1'b0, r_slot} < (SLOT_W + 1)'(NUM_SLOTS));
    assign cur_head   = in_range ? r_head[r_slot]     : NIL;
    assign cur_tail   = in_range ? r_tail[r_slot]     : NIL;
    assign cur_queue  = in_range ? r_is_queue[r_slot] : 1'b0;
    assign cur_exists = in_range ? r_exists[r_slot]   : 1'b0;

    // A stored link above null is treated as null.
    assign next_link = (r_link_rd > NIL) ? NIL : r_link_rd;

    assign rd_ptr = i_cmd.free_rd ? r_free_head : cur_head;

    always_comb begin
        link_we    = 1'b0;
        link_wptr  = r_node;
        link_wdata = NIL;
        if (i_cmd.push_link) begin
            link_we    = 1'b1;
            link_wptr  = cur_tail;
            link_wdata = r_node;
        end else if (i_cmd.push_wr) begin
            link_we    = 1'b1;
            link_wptr  = r_node;
            link_wdata = cur_queue ? NIL : cur_head;
        end else if (i_cmd.pop_commit) begin
            link_we    = 1'b1;
            link_wptr  = cur_head;
            link_wdata = r_free_head;
        end
    end

    // Pool memories: one write and one registered read per cycle. The read
    // registers are loaded only by a free-list or a head read and hold their
    // data for the following cycle.
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_wptr[ADDR_W-1:0]] <= link_wdata;
        end
        if (i_cmd.push_wr) begin
            word_mem[r_node[ADDR_W-1:0]] <= r_val;
        end
        if (i_cmd.free_rd || i_cmd.pop_rd) begin
            r_link_rd <= link_mem[rd_ptr[ADDR_W-1:0]];
            r_word_rd <= word_mem[rd_ptr[ADDR_W-1:0]];
        end
    end

    // Operation capture and node selection.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_slot  <= i_list_slot;
            r_queue <= i_make_queue;
            r_val   <= i_push_value[WORD_WIDTH-1:0];
        end
        if (i_cmd.free_take) begin
            r_node <= r_free_head;
        end else if (i_cmd.fresh_take) begin
            r_node <= r_fresh_count;
        end
        if (i_cmd.done) begin
            r_status   <= i_cmd.status;
            r_pop_word <= i_cmd.pop_commit ? r_word_rd : '0;
        end
    end

    // Slot table, free list and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_exists[i]   <= 1'b0;
                r_is_queue[i] <= 1'b0;
                r_head[i]     <= NIL;
                r_tail[i]     <= NIL;
            end
            r_free_head   <= NIL;
            r_fresh_count <= '0;
            r_valid       <= 1'b0;
            r_pop_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.done;
            if (i_cmd.done) begin
                r_pop_valid <= i_cmd.pop_commit;
            end
            if (i_cmd.create) begin
                r_exists[r_slot]   <= 1'b1;
                r_is_queue[r_slot] <= r_queue;
                r_head[r_slot]     <= NIL;
                r_tail[r_slot]     <= NIL;
            end
            if (i_cmd.free_take) begin
                r_free_head <= next_link;
            end
            if (i_cmd.fresh_take) begin
                r_fresh_count <= r_fresh_count + 1'b1;
            end
            if (i_cmd.push_wr) begin
                if (cur_queue) begin
                    if (cur_tail == NIL) begin
                        r_head[r_slot] <= r_node;
                    end
                    r_tail[r_slot] <= r_node;
                end else begin
                    r_head[r_slot] <= r_node;
                    if (cur_tail == NIL) begin
                        r_tail[r_slot] <= r_node;
                    end
                end
            end
            if (i_cmd.pop_commit) begin
                r_head[r_slot] <= next_link;
                if (next_link == NIL) begin
                    r_tail[r_slot] <= NIL;
                end
                r_free_head <= cur_head;
            end
        end
    end

    always_comb begin
        o_stat.kind        = r_kind;
        o_stat.in_range    = in_range;
        o_stat.exists      = cur_exists;
        o_stat.is_queue    = cur_queue;
        o_stat.head_null   = (cur_head == NIL);
        o_stat.tail_null   = (cur_tail == NIL);
        o_stat.free_avail  = (r_free_head < NIL);
        o_stat.fresh_avail = (r_fresh_count < NIL);
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_popped_value = OUT_W'(r_pop_word);
    assign o_popped_valid = r_pop_valid;

endmodule
`default_nettype wire

@@ sv/multi_list_stack_queue_engine.sv @@
// Top level of the multi-list stack and queue engine.
// Depends on mlsq_pkg, mlsq_ctrl and mlsq_datapath.
//
// The engine keeps up to NUM_SLOTS lists, each created as a stack or a queue,
// sharing one pool of POOL_DEPTH linked nodes. An operation (create, push or
// pop on a slot) is accepted at a rising edge where start is high and busy
// is low. Every operation yields exactly one result, shown on o_status,
// o_popped_value and o_popped_valid for a single cycle while o_valid is
// high. The receiver cannot stall, so each result transfer completes in the
// cycle it is shown, and a new operation may be accepted in that same cycle.
//
// The steps of an operation are set by the node pool memories: they have one
// write port and a registered read, so taking a node off the free list needs a
// read before the take, a pop needs a read of the head before the unlink, and a
// queue push with a non-empty tail needs two link writes. A create, an ignored
// kind or any failing operation finishes at decode. The result appears in the
// cycle after the final operation step.
//
// A synchronous reset (i_rst_n low) empties the slot table, the free list
// and the fresh-node counter at once; pool memories need no clearing because
// a node is always written before it is read.
`default_nettype none
module multi_list_stack_queue_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [mlsq_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [mlsq_pkg::SLOT_W-1:0]   i_list_slot,
    input  wire logic                          i_make_queue,
    input  wire logic [mlsq_pkg::OUT_W-1:0]    i_push_value,
    output logic                               o_valid,
    output logic [mlsq_pkg::STAT_W-1:0]        o_status,
    output logic [mlsq_pkg::OUT_W-1:0]         o_popped_value,
    output logic                               o_popped_valid
);
    import mlsq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // The controller sequences each operation through decode, node
    // allocation, linking and write-back.
    mlsq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // The datapath holds every piece of list state and the result registers.
    mlsq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_kind),
        .i_list_slot    (i_list_slot),
        .i_make_queue   (i_make_queue),
        .i_push_value   (i_push_value),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_popped_valid (o_popped_valid)
    );

endmodule
`default_nettype wire
